// File: rtl/ecf_pkg.sv
`default_nettype none

package ecf_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int AXIS_W     = 24;
	localparam int ORD_W      = 3;
	localparam int NUM_AXES   = 3;
	localparam int DIFF_W     = AXIS_W + 2;
	localparam int SUM_W      = AXIS_W + 1;
	localparam int IN_DATA_W  = 2 * NUM_AXES * AXIS_W;
	localparam int IN_USER_W  = ORD_W;
	localparam int OUT_DATA_W = NUM_AXES * AXIS_W;
	localparam int OUT_USER_W = 1;
	localparam int NUM_STAGES = 9;

	localparam logic [ORD_W-1:0] ORD_XYZ = 3'd0;
	localparam logic [ORD_W-1:0] ORD_XZY = 3'd1;
	localparam logic [ORD_W-1:0] ORD_YXZ = 3'd2;
	localparam logic [ORD_W-1:0] ORD_YZX = 3'd3;
	localparam logic [ORD_W-1:0] ORD_ZXY = 3'd4;
	localparam logic [ORD_W-1:0] ORD_ZYX = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic signed [AXIS_W-1:0] angle_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [ORD_W-1:0]         order_t;
	typedef logic [1:0]               axis_t;

	localparam sum_t ANGLE_MAX = sum_t'((2 ** (AXIS_W - 1)) - 1);
	localparam sum_t ANGLE_MIN = sum_t'(-(2 ** (AXIS_W - 1)));

	function automatic axis_t mid_axis(order_t ord);
		axis_t a;
		case (ord)
			ORD_XYZ: a = AXIS_Y;
			ORD_XZY: a = AXIS_Z;
			ORD_YXZ: a = AXIS_X;
			ORD_YZX: a = AXIS_Z;
			ORD_ZXY: a = AXIS_X;
			ORD_ZYX: a = AXIS_Y;
			default: a = AXIS_X;
		endcase
		return a;
	endfunction

	function automatic logic has_flip(order_t ord);
		return ord <= ORD_ZYX;
	endfunction

	function automatic angle_t sat_angle(sum_t v);
		angle_t r;
		if (v > ANGLE_MAX) begin
			r = angle_t'(ANGLE_MAX);
		end else if (v < ANGLE_MIN) begin
			r = angle_t'(ANGLE_MIN);
		end else begin
			r = angle_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/ecf_mod_turn.sv
`default_nettype none

module ecf_mod_turn
	import ecf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int EW = FRAC_BITS + 9
)(
	input  logic          clk,
	input  logic          en_a,
	input  logic          en_b,
	input  diff_t         x,
	output logic [EW-1:0] e
);

	localparam int SH   = FRAC_BITS + 3;
	localparam int MW   = DIFF_W - SH;
	localparam int BIAS = 45 * (((1 << (MW - 1)) / 45) + 1);
	localparam int UW   = MW + 1;
	localparam int K    = UW + 6;
	localparam int RW   = K - 5;
	localparam int QW   = UW - 5;
	localparam longint RECIP = ((longint'(1) << K) / 45) + 1;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
	localparam logic [UW-1:0] DIVISOR = UW'(45);

	logic signed [MW-1:0] m;
	logic [UW-1:0]        mu;
	logic [UW+RW-1:0]     prod;
	logic [QW-1:0]        q_s2;
	logic [UW-1:0]        mu_s2;
	logic [SH-1:0]        lo_s2;
	logic [UW-1:0]        rem;
	logic [EW-1:0]        e_s3;

	// floor shift, then bias into positive range by a multiple of 45
	assign m    = MW'(x >>> SH);
	assign mu   = UW'(m) + UW'(BIAS);
	assign prod = (UW+RW)'(mu) * (UW+RW)'(RECIP_V);

	always_ff @(posedge clk) begin
		if (en_a) begin
			q_s2  <= prod[K +: QW];
			mu_s2 <= mu;
			lo_s2 <= x[SH-1:0];
		end
	end

	assign rem = mu_s2 - UW'(q_s2) * DIVISOR;

	always_ff @(posedge clk) begin
		if (en_b) begin
			e_s3 <= {rem[5:0], lo_s2};
		end
	end

	assign e = e_s3;

endmodule

`default_nettype wire

// File: rtl/ecf_ctrl.sv
`default_nettype none

module ecf_ctrl
	import ecf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [NUM_STAGES-1:0] en
);

	logic [NUM_STAGES-1:0] vld_q;

	// a stage loads when empty or when the next one loads
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !m_tready) |-> !s_tready)
		else $error("full pipeline took a word while stalled");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> s_tready)
		else $error("empty input stage refused a word");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) == $past($countones(vld_q))
			+ $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready)))
		else $error("words in flight do not match accepted minus delivered");

endmodule

`default_nettype wire

// File: rtl/euler_angle_continuity_filter_top.sv
`default_nettype none

// Channel   Dir  tdata (low bit up)                               tuser
// s_*       in   angle_x, angle_y, angle_z, ref_x, ref_y, ref_z   rotation_order
// m_*       out  filtered_x, filtered_y, filtered_z               used_flip
//
// One word per cycle sustained while m_tready is high; m_tvalid rises when the accepted word reaches the last stage.
// Depth is set by the reciprocal multiply of the turn modulo and the squaring stages.
// Every stage loads when empty or when its successor loads, so bubbles collapse;
// while a result waits on m_tready, input fills empty stages, then s_tready drops.
// arst_n clears only the stage valid bits.

module euler_angle_continuity_filter_top
	import ecf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // angle_x, angle_y, angle_z, ref_x, ref_y, ref_z
	input  logic [IN_USER_W-1:0]  s_tuser,  // rotation_order
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // filtered_x, filtered_y, filtered_z
	output logic [OUT_USER_W-1:0] m_tuser   // used_flip
);

	localparam int EW = FRAC_BITS + 9;
	localparam int OW = EW + 1;
	localparam int FW = EW + 1;
	localparam int DW = 2 * EW;
	localparam logic [EW-1:0] TURN = EW'(360 << FRAC_BITS);
	localparam logic [EW-1:0] HALF = EW'(180 << FRAC_BITS);

	typedef logic signed [OW-1:0] offs_t;
	typedef logic [DW-1:0]        dist_t;
	typedef logic [EW-1:0]        ew_t;
	typedef logic [FW-1:0]        fw_t;

	function automatic offs_t wrap_off(ew_t e, logic le);
		offs_t r;
		if (e == HALF) begin
			r = le ? -offs_t'(HALF) : offs_t'(HALF);
		end else if (e < HALF) begin
			r = offs_t'(e);
		end else begin
			r = offs_t'(e) - offs_t'(TURN);
		end
		return r;
	endfunction

	function automatic dist_t sq_off(offs_t v);
		ew_t mag;
		mag = v[OW-1] ? ew_t'(-v) : ew_t'(v);
		return dist_t'(mag) * dist_t'(mag);
	endfunction

	logic [NUM_STAGES-1:0] en;

	ecf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	// stage 1: input register
	angle_t ang_s1 [NUM_AXES];
	angle_t ref_s1 [NUM_AXES];
	order_t ord_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_s1[i] <= angle_t'(s_tdata[i*AXIS_W +: AXIS_W]);
				ref_s1[i] <= angle_t'(s_tdata[(NUM_AXES+i)*AXIS_W +: AXIS_W]);
			end
			ord_s1 <= s_tuser;
		end
	end

	diff_t diff_s1 [NUM_AXES];
	diff_t nr2_s1;
	logic  le_c [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			diff_s1[i] = diff_t'(ang_s1[i]) - diff_t'(ref_s1[i]);
			le_c[i]    = diff_s1[i] <= 0;
		end
		nr2_s1 = -(diff_t'(ref_s1[mid_axis(ord_s1)]) <<< 1);
	end

	// stages 2-3: turn modulo of each difference and of minus twice the middle ref
	ew_t e_s3 [NUM_AXES];
	ew_t em_s3;

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_mod
		ecf_mod_turn #(.FRAC_BITS(FRAC_BITS)) u_mod (
			.clk  (clk),
			.en_a (en[1]),
			.en_b (en[2]),
			.x    (diff_s1[g]),
			.e    (e_s3[g])
		);
	end

	ecf_mod_turn #(.FRAC_BITS(FRAC_BITS)) u_mod_mid (
		.clk  (clk),
		.en_a (en[1]),
		.en_b (en[2]),
		.x    (nr2_s1),
		.e    (em_s3)
	);

	angle_t ref_s2 [NUM_AXES];
	angle_t ref_s3 [NUM_AXES];
	order_t ord_s2, ord_s3;
	logic   le_s2 [NUM_AXES];
	logic   le_s3 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ref_s2 <= ref_s1;
			ord_s2 <= ord_s1;
			le_s2  <= le_c;
		end
		if (en[2]) begin
			ref_s3 <= ref_s2;
			ord_s3 <= ord_s2;
			le_s3  <= le_s2;
		end
	end

	// stage 4: offsets and unwrapped angles
	offs_t  off_s4 [NUM_AXES];
	sum_t   u_s4 [NUM_AXES];
	angle_t ref_s4 [NUM_AXES];
	order_t ord_s4;
	ew_t    em_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				off_s4[i] <= wrap_off(e_s3[i], le_s3[i]);
				u_s4[i]   <= sum_t'(ref_s3[i]) + sum_t'(wrap_off(e_s3[i], le_s3[i]));
			end
			ref_s4 <= ref_s3;
			ord_s4 <= ord_s3;
			em_s4  <= em_s3;
		end
	end

	// stage 5: squares, flipped differences before reduction
	fw_t  fe_c [NUM_AXES];
	logic fle_c [NUM_AXES];
	sum_t fl_c [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			if (i == int'(mid_axis(ord_s4))) begin
				fe_c[i] = fw_t'(HALF) - fw_t'(off_s4[i]) + fw_t'(em_s4);
				fl_c[i] = sum_t'(HALF) - u_s4[i];
			end else begin
				fe_c[i] = fw_t'(off_s4[i]) + fw_t'(HALF);
				fl_c[i] = u_s4[i] + sum_t'(HALF);
			end
			fle_c[i] = fl_c[i] <= sum_t'(ref_s4[i]);
		end
	end

	dist_t  sq_s5 [NUM_AXES];
	fw_t    fe_s5 [NUM_AXES];
	logic   fle_s5 [NUM_AXES];
	sum_t   u_s5 [NUM_AXES];
	angle_t ref_s5 [NUM_AXES];
	logic   fv_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_s5[i] <= sq_off(off_s4[i]);
			end
			fe_s5  <= fe_c;
			fle_s5 <= fle_c;
			u_s5   <= u_s4;
			ref_s5 <= ref_s4;
			fv_s5  <= has_flip(ord_s4);
		end
	end

	// stage 6: flipped offsets, unflipped distance
	fw_t fr_c [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			fr_c[i] = (fe_s5[i] >= fw_t'(TURN)) ? fe_s5[i] - fw_t'(TURN) : fe_s5[i];
		end
	end

	offs_t  foff_s6 [NUM_AXES];
	dist_t  dist_s6;
	sum_t   u_s6 [NUM_AXES];
	angle_t ref_s6 [NUM_AXES];
	logic   fv_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				foff_s6[i] <= wrap_off(ew_t'(fr_c[i]), fle_s5[i]);
			end
			dist_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			u_s6    <= u_s5;
			ref_s6  <= ref_s5;
			fv_s6   <= fv_s5;
		end
	end

	// stage 7: flipped squares and angles
	dist_t fsq_s7 [NUM_AXES];
	sum_t  fu_s7 [NUM_AXES];
	sum_t  u_s7 [NUM_AXES];
	dist_t dist_s7;
	logic  fv_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				fsq_s7[i] <= sq_off(foff_s6[i]);
				fu_s7[i]  <= sum_t'(ref_s6[i]) + sum_t'(foff_s6[i]);
			end
			u_s7    <= u_s6;
			dist_s7 <= dist_s6;
			fv_s7   <= fv_s6;
		end
	end

	// stage 8: flipped distance, saturated candidates
	dist_t  fdist_s8;
	dist_t  dist_s8;
	angle_t usat_s8 [NUM_AXES];
	angle_t fsat_s8 [NUM_AXES];
	logic   fv_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			fdist_s8 <= fsq_s7[0] + fsq_s7[1] + fsq_s7[2];
			for (int i = 0; i < NUM_AXES; i++) begin
				usat_s8[i] <= sat_angle(u_s7[i]);
				fsat_s8[i] <= sat_angle(fu_s7[i]);
			end
			dist_s8 <= dist_s7;
			fv_s8   <= fv_s7;
		end
	end

	// stage 9: pick and hold for output
	angle_t res_s9 [NUM_AXES];
	logic   flip_s9;
	logic   pick_c;

	assign pick_c = fv_s8 && (dist_s8 > fdist_s8);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			flip_s9 <= pick_c;
			for (int i = 0; i < NUM_AXES; i++) begin
				res_s9[i] <= pick_c ? fsat_s8[i] : usat_s8[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			m_tdata[i*AXIS_W +: AXIS_W] = res_s9[i];
		end
	end

	assign m_tuser = flip_s9;

endmodule

`default_nettype wire
